// ===== rtl/rbht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rounded border hit test package
// Widths, register indexes and shared types for the border hit test.
// ----------------------------------------------------------------------------
package rbht_pkg;

	// Point coordinates are two's complement of this width.
	localparam int COORD_BITS = 16;

	localparam int FRAME_BITS = 14;
	localparam int RAD_BITS   = 12;

	// Working width for signed sums of coordinates and frame geometry.
	localparam int GEOM_BITS = (COORD_BITS > FRAME_BITS + 1) ? COORD_BITS : FRAME_BITS + 1;
	localparam int EXT_BITS  = GEOM_BITS + 2;

	// Squared distances of points already known to lie within one radius.
	localparam int SQ_BITS = 2 * RAD_BITS + 1;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = FRAME_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH         = 3'd0,
		REG_FRAME_HEIGHT        = 3'd1,
		REG_BORDER_WIDTH        = 3'd2,
		REG_RADIUS_TOP_LEFT     = 3'd3,
		REG_RADIUS_TOP_RIGHT    = 3'd4,
		REG_RADIUS_BOTTOM_LEFT  = 3'd5,
		REG_RADIUS_BOTTOM_RIGHT = 3'd6
	} cfg_reg_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [EXT_BITS-1:0]   ext_t;
	typedef logic [RAD_BITS-1:0]          rad_t;
	typedef logic [FRAME_BITS-1:0]        frame_t;

endpackage

// ===== rtl/rbht_point_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point channel
// Valid/ready channel carrying one point relative to the frame's corner.
// ----------------------------------------------------------------------------
interface rbht_point_if import rbht_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t point_x;
	coord_t point_y;

	modport source (output valid, output point_x, output point_y, input ready);
	modport sink (input valid, input point_x, input point_y, output ready);
endinterface

// ===== rtl/rbht_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the hit flag for one point.
// ----------------------------------------------------------------------------
interface rbht_result_if ();
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, output hit, input ready);
	modport sink (input valid, input hit, output ready);
endinterface

// ===== rtl/rbht_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface rbht_cfg_if import rbht_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rbht_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Corner ring test
// Decides whether an offset from an arc centre lies on the quarter ring.
// ----------------------------------------------------------------------------
module rbht_ring import rbht_pkg::*; (
	input  ext_t dx,
	input  ext_t dy,
	input  rad_t radius,
	input  rad_t border,
	output logic hit
);

	logic [EXT_BITS-1:0] abs_x;
	logic [EXT_BITS-1:0] abs_y;
	logic                near;
	rad_t                mag_x;
	rad_t                mag_y;
	logic [SQ_BITS-1:0]  dist_sq;
	logic [SQ_BITS-1:0]  outer_sq;
	logic                has_inner;
	rad_t                inner;
	logic [SQ_BITS-1:0]  inner_sq;

	assign abs_x = dx[EXT_BITS-1] ? EXT_BITS'(-dx) : EXT_BITS'(dx);
	assign abs_y = dy[EXT_BITS-1] ? EXT_BITS'(-dy) : EXT_BITS'(dy);

	// Any offset beyond the radius on one axis is already outside the disc,
	// so only narrow magnitudes ever reach the squarers.
	assign near  = (abs_x <= EXT_BITS'(radius)) && (abs_y <= EXT_BITS'(radius));
	assign mag_x = abs_x[RAD_BITS-1:0];
	assign mag_y = abs_y[RAD_BITS-1:0];

	assign dist_sq   = SQ_BITS'(mag_x * mag_x) + SQ_BITS'(mag_y * mag_y);
	assign outer_sq  = SQ_BITS'(radius * radius);
	assign has_inner = radius > border;
	assign inner     = radius - border;
	assign inner_sq  = SQ_BITS'(inner * inner);

	assign hit = near && (dist_sq <= outer_sq) && !(has_inner && (dist_sq < inner_sq));

endmodule

// ===== rtl/rounded_border_hit_test_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rounded border hit test core
// Reports whether a point hits a frame border made of four bands and four
// quarter-ring corner arcs.
//
// Channel  Role    Payload                       Transaction when
// point    sink    point_x, point_y (signed)     point.valid && point.ready
// result   source  hit                           result.valid && result.ready
// cfg      sink    index, data                   cfg.valid && cfg.ready
//
// An accepted point goes from the input register to the result register,
// which offers its result. One point is accepted per cycle unless the output
// stalls; the rate is set by the single compute stage between them.
// The result register lets a new point enter while a result waits to be taken.
// Reset clears the valid flags and all configuration registers to zero.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
module rounded_border_hit_test_core import rbht_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	rbht_point_if.sink    point,
	rbht_result_if.source result,
	rbht_cfg_if.sink      cfg
);

	frame_t frame_width_q;
	frame_t frame_height_q;
	rad_t   border_width_q;
	rad_t   radius_tl_q;
	rad_t   radius_tr_q;
	rad_t   radius_bl_q;
	rad_t   radius_br_q;

	logic   valid_s1;
	coord_t point_x_s1;
	coord_t point_y_s1;
	logic   valid_q;
	logic   hit_q;

	logic   out_free;
	logic   adv_s1;
	logic   take_in;

	ext_t   px;
	ext_t   py;
	ext_t   w;
	ext_t   h;
	ext_t   b;
	ext_t   rtl;
	ext_t   rtr;
	ext_t   rbl;
	ext_t   rbr;
	logic   band_left;
	logic   band_right;
	logic   band_top;
	logic   band_bottom;
	ext_t   dx_tl;
	ext_t   dy_tl;
	ext_t   dx_tr;
	ext_t   dy_tr;
	ext_t   dx_bl;
	ext_t   dy_bl;
	ext_t   dx_br;
	ext_t   dy_br;
	logic   ring_tl;
	logic   ring_tr;
	logic   ring_bl;
	logic   ring_br;
	logic   quad_tl;
	logic   quad_tr;
	logic   quad_bl;
	logic   quad_br;
	logic   hit_s1;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= '0;
			frame_height_q <= '0;
			border_width_q <= '0;
			radius_tl_q    <= '0;
			radius_tr_q    <= '0;
			radius_bl_q    <= '0;
			radius_br_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FRAME_WIDTH:         frame_width_q  <= cfg.data;
				REG_FRAME_HEIGHT:        frame_height_q <= cfg.data;
				REG_BORDER_WIDTH:        border_width_q <= cfg.data[RAD_BITS-1:0];
				REG_RADIUS_TOP_LEFT:     radius_tl_q    <= cfg.data[RAD_BITS-1:0];
				REG_RADIUS_TOP_RIGHT:    radius_tr_q    <= cfg.data[RAD_BITS-1:0];
				REG_RADIUS_BOTTOM_LEFT:  radius_bl_q    <= cfg.data[RAD_BITS-1:0];
				REG_RADIUS_BOTTOM_RIGHT: radius_br_q    <= cfg.data[RAD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Flow control: the result register frees as it is read, and the input
	// register moves on whenever the result register can take its answer.
	assign out_free    = !valid_q || result.ready;
	assign adv_s1      = valid_s1 && out_free;
	assign point.ready = !valid_s1 || out_free;
	assign take_in     = point.valid && point.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (point.ready) begin
			valid_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			point_x_s1 <= point.point_x;
			point_y_s1 <= point.point_y;
		end
	end

	// Geometry in a common signed width.
	assign px  = EXT_BITS'(point_x_s1);
	assign py  = EXT_BITS'(point_y_s1);
	assign w   = signed'(EXT_BITS'(frame_width_q));
	assign h   = signed'(EXT_BITS'(frame_height_q));
	assign b   = signed'(EXT_BITS'(border_width_q));
	assign rtl = signed'(EXT_BITS'(radius_tl_q));
	assign rtr = signed'(EXT_BITS'(radius_tr_q));
	assign rbl = signed'(EXT_BITS'(radius_bl_q));
	assign rbr = signed'(EXT_BITS'(radius_br_q));

	// A band with no extent cannot satisfy both of its half-open bounds, so
	// the bounds alone decide each band.
	assign band_left   = (px >= 0) && (px < b) && (py >= rtl) && (py < h - rbl);
	assign band_right  = (px >= w - b) && (px < w) && (py >= rtr) && (py < h - rbr);
	assign band_top    = (px >= rtl) && (px < w - rtr) && (py >= 0) && (py < b);
	assign band_bottom = (px >= rbl) && (px < w - rbr) && (py >= h - b) && (py < h);

	assign dx_tl = px - rtl;
	assign dy_tl = py - rtl;
	assign dx_tr = px - (w - rtr);
	assign dy_tr = py - rtr;
	assign dx_bl = px - rbl;
	assign dy_bl = py - (h - rbl);
	assign dx_br = px - (w - rbr);
	assign dy_br = py - (h - rbr);

	// Quadrant edges follow an angle taken over the half-open full turn:
	// the ray straight right of a centre belongs to the bottom-right arc,
	// and the bottom-right arc excludes its own centre.
	assign quad_tl = (dx_tl <= 0) && (dy_tl <= 0);
	assign quad_tr = (dx_tr >= 0) && (dy_tr < 0);
	assign quad_bl = (dx_bl <= 0) && (dy_bl >= 0);
	assign quad_br = (dx_br >= 0) && (dy_br >= 0) && !((dx_br == 0) && (dy_br == 0));

	rbht_ring u_ring_tl (.dx(dx_tl), .dy(dy_tl), .radius(radius_tl_q),
		.border(border_width_q), .hit(ring_tl));
	rbht_ring u_ring_tr (.dx(dx_tr), .dy(dy_tr), .radius(radius_tr_q),
		.border(border_width_q), .hit(ring_tr));
	rbht_ring u_ring_bl (.dx(dx_bl), .dy(dy_bl), .radius(radius_bl_q),
		.border(border_width_q), .hit(ring_bl));
	rbht_ring u_ring_br (.dx(dx_br), .dy(dy_br), .radius(radius_br_q),
		.border(border_width_q), .hit(ring_br));

	assign hit_s1 = band_left || band_right || band_top || band_bottom
		|| (quad_tl && ring_tl) || (quad_tr && ring_tr)
		|| (quad_bl && ring_bl) || (quad_br && ring_br);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			hit_q <= hit_s1;
		end
	end

	assign result.valid = valid_q;
	assign result.hit   = hit_q;

	// A point held in the input register is never dropped while the result
	// register is blocked.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1)
		else $error("input stage lost a point while the output was stalled");

	// An accepted point always reaches the input register.
	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take_in |=> valid_s1)
		else $error("accepted point did not reach the input stage");

	// Every point leaving the input register lands in the result register.
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_q)
		else $error("computed result did not reach the result register");

	// Accepting a new point while the input register is full needs the
	// occupant to move on in the same cycle.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		take_in && valid_s1 |-> adv_s1)
		else $error("input stage overwritten before its point moved on");

endmodule
